>>> src/blld_pkg.sv
// ============================================================================
// Batch-aware least-load dispatch package
// Shared widths, register indexes, state encoding and datapath types.
// ============================================================================
package blld_pkg;

    localparam int MAX_WORKERS = 64;
    localparam int IDX_W       = $clog2(MAX_WORKERS);
    localparam int NW_W        = $clog2(MAX_WORKERS + 1);
    localparam int LEN_W       = 48;
    localparam int CNT_W       = 32;
    localparam int REQ_W       = 32;
    localparam int RND_W       = 16;
    localparam int BATCH_W     = 16;
    localparam int CFG_AW      = 1;
    localparam int CFG_DW      = 16;
    localparam int KW          = CNT_W + 1;
    localparam int HALF_W      = LEN_W / 2;
    localparam int PP_W        = HALF_W + KW;
    localparam int PROD_W      = LEN_W + KW;

    localparam logic [BATCH_W-1:0] BATCH_RESET   = BATCH_W'(5);
    localparam logic [BATCH_W-1:0] BATCH_DEFAULT = BATCH_W'(16);
    localparam logic [NW_W-1:0]    ACTIVE_RESET  = NW_W'(1);

    localparam logic [CFG_AW-1:0] REG_BATCH_SIZE     = CFG_AW'(0);
    localparam logic [CFG_AW-1:0] REG_ACTIVE_WORKERS = CFG_AW'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_MOD,
        ST_TIE_RD,
        ST_ENT_RD,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic [LEN_W-1:0] len_sum;
        logic [CNT_W-1:0] req_cnt;
    } t_worker;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic [LEN_W-1:0] len_sum;
        logic [CNT_W-1:0] req_cnt;
    } t_entry;

    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  idx;
        logic [PROD_W-1:0] prod;
    } t_score;

endpackage

>>> src/blld_score.sv
// ============================================================================
// Worker score pipeline
// Computes length_sum * (ceil(count / batch) + 1) with a bit-per-stage divider
// followed by a split multiplier; accepts one worker entry per cycle.
// ============================================================================
module blld_score (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [blld_pkg::BATCH_W-1:0]        i_batch,
    input  blld_pkg::t_entry                    i_entry,
    output blld_pkg::t_score                    o_score
);
    import blld_pkg::*;

    localparam int DIV_STG = CNT_W;

    function automatic logic [BATCH_W+CNT_W-1:0] div_step(
        input logic [BATCH_W-1:0] rem,
        input logic [CNT_W-1:0]   quo,
        input logic [BATCH_W-1:0] div
    );
        logic [BATCH_W:0]   t;
        logic               ge;
        logic [BATCH_W:0]   diff;
        logic [BATCH_W-1:0] rem_n;
        t     = {rem, quo[CNT_W-1]};
        ge    = (t >= {1'b0, div});
        diff  = t - {1'b0, div};
        rem_n = ge ? diff[BATCH_W-1:0] : t[BATCH_W-1:0];
        return {rem_n, quo[CNT_W-2:0], ge};
    endfunction

    logic [DIV_STG:0]     r_vld;
    logic [IDX_W-1:0]     r_idx [0:DIV_STG];
    logic [LEN_W-1:0]     r_sum [0:DIV_STG];
    logic [BATCH_W-1:0]   r_rem [0:DIV_STG];
    logic [CNT_W-1:0]     r_quo [0:DIV_STG];

    logic                 r_k_vld;
    logic [IDX_W-1:0]     r_k_idx;
    logic [LEN_W-1:0]     r_k_sum;
    logic [KW-1:0]        r_k;

    logic                 r_p_vld;
    logic [IDX_W-1:0]     r_p_idx;
    logic [PP_W-1:0]      r_p0;
    logic [PP_W-1:0]      r_p1;

    logic                 r_s_vld;
    logic [IDX_W-1:0]     r_s_idx;
    logic [PROD_W-1:0]    r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_k_vld <= 1'b0;
            r_p_vld <= 1'b0;
            r_s_vld <= 1'b0;
        end else begin
            r_vld   <= {r_vld[DIV_STG-1:0], i_entry.valid};
            r_k_vld <= r_vld[DIV_STG];
            r_p_vld <= r_k_vld;
            r_s_vld <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx[0] <= i_entry.idx;
        r_sum[0] <= i_entry.len_sum;
        r_rem[0] <= '0;
        r_quo[0] <= i_entry.req_cnt;
        for (int k = 0; k < DIV_STG; k++) begin
            {r_rem[k+1], r_quo[k+1]} <= div_step(r_rem[k], r_quo[k], i_batch);
            r_idx[k+1] <= r_idx[k];
            r_sum[k+1] <= r_sum[k];
        end

        r_k     <= KW'(r_quo[DIV_STG]) + KW'(r_rem[DIV_STG] != '0) + KW'(1);
        r_k_idx <= r_idx[DIV_STG];
        r_k_sum <= r_sum[DIV_STG];

        r_p0    <= PP_W'(r_k_sum[HALF_W-1:0]) * PP_W'(r_k);
        r_p1    <= PP_W'(r_k_sum[LEN_W-1:HALF_W]) * PP_W'(r_k);
        r_p_idx <= r_k_idx;

        r_prod  <= PROD_W'(r_p0) + (PROD_W'(r_p1) << HALF_W);
        r_s_idx <= r_p_idx;
    end

    assign o_score.valid = r_s_vld;
    assign o_score.idx   = r_s_idx;
    assign o_score.prod  = r_prod;

endmodule

>>> src/batch_aware_least_load_dispatch.sv
// ============================================================================
// Batch-aware least-load dispatch
// Picks the worker with the lowest batch-weighted load for each request.
// ============================================================================
// A transaction is accepted on a rising edge with start high and busy low; it
// carries i_request_length and i_tie_random. Every active worker is scored as
// its length sum times (ceil(request count / batch size) + 1). The workers with
// the lowest score are collected in index order and one is picked by the
// random word modulo their number. The chosen worker's length sum and request
// count are incremented with saturation.
// The result appears on o_chosen_worker and o_tie_count for exactly one cycle
// with o_result_valid high; the receiver cannot stall it.
// The n active worker entries are read one per cycle from the worker table into a
// 36-stage divide and multiply pipeline, which then drains; a 16-step modulo
// and the tie lookup, entry read and write states for the read-modify-write of
// the chosen entry follow. busy stays high until the write state has passed,
// and the next transaction can be accepted once it is low again.
// Configuration writes through i_cfg_we, i_cfg_addr and i_cfg_wdata take effect
// at once; the user must make them only while busy is low, as the block itself
// does not enforce this. Reset clears all worker loads through per-entry valid
// flags and restores batch size 5 and one worker.
// ============================================================================
module batch_aware_least_load_dispatch (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [blld_pkg::REQ_W-1:0]        i_request_length,
    input  logic [blld_pkg::RND_W-1:0]        i_tie_random,
    input  logic                              i_cfg_we,
    input  logic [blld_pkg::CFG_AW-1:0]       i_cfg_addr,
    input  logic [blld_pkg::CFG_DW-1:0]       i_cfg_wdata,
    output logic                              o_result_valid,
    output logic [blld_pkg::IDX_W-1:0]        o_chosen_worker,
    output logic [blld_pkg::NW_W-1:0]         o_tie_count
);
    import blld_pkg::*;

    localparam int MOD_STEPS = RND_W;
    localparam int STEP_W    = $clog2(MOD_STEPS);

    t_state               r_state;
    t_state               n_state;

    logic [BATCH_W-1:0]   r_batch_size;
    logic [NW_W-1:0]      r_active_workers;

    logic [BATCH_W-1:0]   r_batch;
    logic [NW_W-1:0]      r_n;
    logic [REQ_W-1:0]     r_len;
    logic [RND_W-1:0]     r_rnd;

    t_worker              r_mem [0:MAX_WORKERS-1];
    logic [MAX_WORKERS-1:0] r_mem_ok;
    t_worker              r_rd_data;
    logic                 r_rd_ok;
    logic                 r_scan_rd;
    logic [IDX_W-1:0]     r_scan_idx_q;
    logic [IDX_W-1:0]     s_rd_addr;

    logic [NW_W-1:0]      r_idx;
    logic [NW_W-1:0]      r_seen;
    logic [PROD_W-1:0]    r_min;
    logic [NW_W-1:0]      r_tie_cnt;
    logic [IDX_W-1:0]     r_ties [0:MAX_WORKERS-1];
    logic [IDX_W-1:0]     r_tie_q;

    logic [RND_W-1:0]     r_mw;
    logic [NW_W-1:0]      r_mr;
    logic [STEP_W-1:0]    r_step;

    logic                 r_out_vld;
    logic [IDX_W-1:0]     r_out_worker;
    logic [NW_W-1:0]      r_out_ties;

    logic                 s_accept;
    logic                 s_busy;
    logic                 s_issue;
    logic                 s_mod_load;
    logic                 s_mod_run;
    logic                 s_write;
    logic                 s_new_min;
    logic                 s_eq;
    logic [NW_W-1:0]      s_mt;
    logic                 s_mge;
    logic [LEN_W:0]       s_sum_ext;
    t_worker              s_upd;
    t_entry               s_entry;
    t_score               s_score;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (start) begin
                           n_state = ST_SCAN;
                       end
            ST_SCAN:   if (r_idx + NW_W'(1) == r_n) begin
                           n_state = ST_DRAIN;
                       end
            ST_DRAIN:  if (r_seen == r_n) begin
                           n_state = ST_MOD;
                       end
            ST_MOD:    if (r_step == STEP_W'(MOD_STEPS - 1)) begin
                           n_state = ST_TIE_RD;
                       end
            ST_TIE_RD: n_state = ST_ENT_RD;
            ST_ENT_RD: n_state = ST_WRITE;
            ST_WRITE:  n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_busy     = 1'b1;
        s_issue    = 1'b0;
        s_mod_load = 1'b0;
        s_mod_run  = 1'b0;
        s_write    = 1'b0;
        unique case (r_state)
            ST_IDLE:   s_busy     = 1'b0;
            ST_SCAN:   s_issue    = 1'b1;
            ST_DRAIN:  s_mod_load = 1'b1;
            ST_MOD:    s_mod_run  = 1'b1;
            ST_TIE_RD: s_busy     = 1'b1;
            ST_ENT_RD: s_busy     = 1'b1;
            ST_WRITE:  s_write    = 1'b1;
            default:   s_busy     = 1'b1;
        endcase
    end

    assign s_accept = start && !s_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batch_size     <= BATCH_RESET;
            r_active_workers <= ACTIVE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_BATCH_SIZE:     r_batch_size     <= i_cfg_wdata[BATCH_W-1:0];
                REG_ACTIVE_WORKERS: r_active_workers <= i_cfg_wdata[NW_W-1:0];
                default:            r_batch_size     <= r_batch_size;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_batch <= (r_batch_size == '0) ? BATCH_DEFAULT : r_batch_size;
            if (r_active_workers == '0) begin
                r_n <= NW_W'(1);
            end else if (r_active_workers > NW_W'(MAX_WORKERS)) begin
                r_n <= NW_W'(MAX_WORKERS);
            end else begin
                r_n <= r_active_workers;
            end
            r_len <= i_request_length;
            r_rnd <= i_tie_random;
        end
    end

    assign s_rd_addr = s_issue ? r_idx[IDX_W-1:0] : r_tie_q;

    always_ff @(posedge i_clk) begin
        r_rd_data    <= r_mem[s_rd_addr];
        r_rd_ok      <= r_mem_ok[s_rd_addr];
        r_scan_idx_q <= s_rd_addr;
        if (s_write) begin
            r_mem[r_tie_q] <= s_upd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_ok  <= '0;
            r_scan_rd <= 1'b0;
            r_idx     <= '0;
        end else begin
            if (s_write) begin
                r_mem_ok[r_tie_q] <= 1'b1;
            end
            r_scan_rd <= s_issue;
            if (s_accept) begin
                r_idx <= '0;
            end else if (s_issue) begin
                r_idx <= r_idx + NW_W'(1);
            end
        end
    end

    assign s_entry.valid   = r_scan_rd;
    assign s_entry.idx     = r_scan_idx_q;
    assign s_entry.len_sum = r_rd_ok ? r_rd_data.len_sum : '0;
    assign s_entry.req_cnt = r_rd_ok ? r_rd_data.req_cnt : '0;

    blld_score u_score (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_batch (r_batch),
        .i_entry (s_entry),
        .o_score (s_score)
    );

    assign s_new_min = (r_tie_cnt == '0) || (s_score.prod < r_min);
    assign s_eq      = (s_score.prod == r_min);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= '0;
            r_tie_cnt <= '0;
        end else if (s_accept) begin
            r_seen    <= '0;
            r_tie_cnt <= '0;
        end else if (s_score.valid) begin
            r_seen <= r_seen + NW_W'(1);
            if (s_new_min) begin
                r_tie_cnt <= NW_W'(1);
            end else if (s_eq) begin
                r_tie_cnt <= r_tie_cnt + NW_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_score.valid) begin
            if (s_new_min) begin
                r_min    <= s_score.prod;
                r_ties[0] <= s_score.idx;
            end else if (s_eq) begin
                r_ties[r_tie_cnt[IDX_W-1:0]] <= s_score.idx;
            end
        end
        r_tie_q <= r_ties[r_mr[IDX_W-1:0]];
    end

    assign s_mt  = {r_mr[NW_W-2:0], r_mw[RND_W-1]};
    assign s_mge = (s_mt >= r_tie_cnt);

    always_ff @(posedge i_clk) begin
        if (s_mod_load) begin
            r_mw   <= r_rnd;
            r_mr   <= '0;
            r_step <= '0;
        end else if (s_mod_run) begin
            r_mw   <= {r_mw[RND_W-2:0], 1'b0};
            r_mr   <= s_mge ? (s_mt - r_tie_cnt) : s_mt;
            r_step <= r_step + STEP_W'(1);
        end
    end

    assign s_sum_ext = {1'b0, (r_rd_ok ? r_rd_data.len_sum : LEN_W'(0))}
                     + (LEN_W + 1)'(r_len);

    always_comb begin
        s_upd.len_sum = s_sum_ext[LEN_W] ? '1 : s_sum_ext[LEN_W-1:0];
        s_upd.req_cnt = r_rd_ok ? r_rd_data.req_cnt : '0;
        if (s_upd.req_cnt != '1) begin
            s_upd.req_cnt = s_upd.req_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= s_write;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_write) begin
            r_out_worker <= r_tie_q;
            r_out_ties   <= r_tie_cnt;
        end
    end

    assign busy            = s_busy;
    assign o_result_valid  = r_out_vld;
    assign o_chosen_worker = r_out_worker;
    assign o_tie_count     = r_out_ties;

endmodule
